// ===== sv/top_k_nearest_slot_tracker_macros.svh =====
// assertion macros used by the checker file
`ifndef TOP_K_NEAREST_SLOT_TRACKER_MACROS_SVH
`define TOP_K_NEAREST_SLOT_TRACKER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TKNST_ASSERT_SAME(name, clock, resetn, pre, post) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |-> (post)) \
        else $error("tknst check failed");

// next-cycle implication, disabled in reset
`define TKNST_ASSERT_NEXT(name, clock, resetn, pre, post) \
    name: assert property (@(posedge clock) disable iff (!resetn) (pre) |=> (post)) \
        else $error("tknst check failed");

`endif

// ===== sv/tknst_pkg.sv =====
// shared types, constants and op codes of the top-k slot tracker
`default_nettype none

package tknst_pkg;

    localparam int DEF_GRID_WIDTH  = 32;
    localparam int DEF_GRID_HEIGHT = 32;
    localparam int DEF_TOP         = 4;

    localparam int OP_W    = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int SEL_W   = 4;
    localparam int DIST_W  = 32;
    localparam int LABEL_W = 16;
    localparam int BYTE_W  = 8;

    localparam logic [DIST_W-1:0] MAX_SAMPLES  = 32'd65536;
    localparam logic [DIST_W-1:0] FAR_DISTANCE = 32'h7fff_ffff;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0]  dval;
        logic [LABEL_W-1:0] label;
        logic [BYTE_W-1:0]  obyte;
    } slot_t;

    typedef struct packed {
        logic init_wr;
        logic capture;
        logic ram_rd;
        logic clear_wr;
        logic load;
        logic scan_step;
        logic update_wr;
        logic emit_zero;
        logic emit_read;
        logic emit_update;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic skip;
        logic op_clear;
        logic op_read;
        logic scan_last;
        logic better;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/top_k_nearest_slot_tracker.sv =====
// top level of the top-k nearest slot tracker
`default_nettype none

// Keeps TOP best (smallest distance) slots per grid position in one memory
// row per position. A word is taken when start is high and busy is low; its
// result appears for exactly one cycle with done high, and cannot be held off.
// After reset the block runs a clearing pass over all GRID_WIDTH*GRID_HEIGHT
// positions with busy high. A clear, an ignored word or a read beyond TOP is
// answered from the issue state; a read first reads the memory row; an offer
// takes one memory read, a scan of one slot per cycle to find the largest
// stored distance, then the row write-back if the offer is smaller. busy falls
// with done, so the next word may be taken in the done cycle.
module top_k_nearest_slot_tracker #(
    parameter int GRID_WIDTH  = tknst_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = tknst_pkg::DEF_GRID_HEIGHT,
    parameter int TOP         = tknst_pkg::DEF_TOP
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tknst_pkg::OP_W-1:0]    op,
    input  wire logic [tknst_pkg::ROW_W-1:0]   row,
    input  wire logic [tknst_pkg::COL_W-1:0]   col,
    input  wire logic [tknst_pkg::SEL_W-1:0]   slot_sel,
    input  wire logic [tknst_pkg::DIST_W-1:0]  distance,
    input  wire logic [tknst_pkg::LABEL_W-1:0] sample_index,
    input  wire logic [tknst_pkg::BYTE_W-1:0]  sample_output,
    output logic                               done,
    output logic                               accepted,
    output logic      [tknst_pkg::SEL_W-1:0]   slot,
    output logic      [tknst_pkg::DIST_W-1:0]  out_distance,
    output logic      [tknst_pkg::LABEL_W-1:0] out_label,
    output logic      [tknst_pkg::BYTE_W-1:0]  out_byte
);

    import tknst_pkg::*;

    cmd_t    cmd;
    status_t sts;

    tknst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    tknst_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .TOP         (TOP)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .row           (row),
        .col           (col),
        .slot_sel      (slot_sel),
        .distance      (distance),
        .sample_index  (sample_index),
        .sample_output (sample_output),
        .done          (done),
        .accepted      (accepted),
        .slot          (slot),
        .out_distance  (out_distance),
        .out_label     (out_label),
        .out_byte      (out_byte)
    );

endmodule

`default_nettype wire

// ===== sv/tknst_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module tknst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tknst_ctrl.sv =====
// controller state machine of the top-k slot tracker
`default_nettype none

module tknst_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire tknst_pkg::status_t sts,
    output logic                   busy,
    output tknst_pkg::cmd_t        cmd
);

    import tknst_pkg::*;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ISSUE  = 6'b000100,
        S_LOAD   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (sts.skip)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.op_clear)
                begin
                    cmd.clear_wr  = 1'b1;
                    cmd.emit_zero = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.op_read)
                begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.better)
                begin
                    cmd.update_wr   = 1'b1;
                    cmd.emit_update = 1'b1;
                end
                else
                begin
                    cmd.emit_zero = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tknst_dp.sv =====
// datapath: item registers, slot memory, worst-slot scan and result word
`default_nettype none

module tknst_dp #(
    parameter int GRID_WIDTH  = tknst_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = tknst_pkg::DEF_GRID_HEIGHT,
    parameter int TOP         = tknst_pkg::DEF_TOP
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tknst_pkg::cmd_t               cmd,
    output tknst_pkg::status_t                 sts,
    input  wire logic [tknst_pkg::OP_W-1:0]    op,
    input  wire logic [tknst_pkg::ROW_W-1:0]   row,
    input  wire logic [tknst_pkg::COL_W-1:0]   col,
    input  wire logic [tknst_pkg::SEL_W-1:0]   slot_sel,
    input  wire logic [tknst_pkg::DIST_W-1:0]  distance,
    input  wire logic [tknst_pkg::LABEL_W-1:0] sample_index,
    input  wire logic [tknst_pkg::BYTE_W-1:0]  sample_output,
    output logic                               done,
    output logic                               accepted,
    output logic      [tknst_pkg::SEL_W-1:0]   slot,
    output logic      [tknst_pkg::DIST_W-1:0]  out_distance,
    output logic      [tknst_pkg::LABEL_W-1:0] out_label,
    output logic      [tknst_pkg::BYTE_W-1:0]  out_byte
);

    import tknst_pkg::*;

    localparam int POSITIONS = GRID_WIDTH * GRID_HEIGHT;
    localparam int POS_W     = POSITIONS > 1 ? $clog2(POSITIONS) : 1;
    localparam int IDX_W     = TOP > 1 ? $clog2(TOP) : 1;
    localparam int ROW_BITS  = TOP * $bits(slot_t);

    typedef slot_t [TOP-1:0] row_t;

    logic [OP_W-1:0]    op_reg;
    logic [ROW_W-1:0]   row_idx_reg;
    logic [COL_W-1:0]   col_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [BYTE_W-1:0]  obyte_reg;

    logic [POS_W-1:0]   init_cnt_reg;
    logic [POS_W-1:0]   init_cnt_next;

    row_t               slots_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   worst_idx_reg;
    logic [DIST_W-1:0]  worst_dist_reg;

    logic               done_next;
    logic               accepted_next;
    logic [SEL_W-1:0]   slot_next;
    logic [DIST_W-1:0]  out_distance_next;
    logic [LABEL_W-1:0] out_label_next;
    logic [BYTE_W-1:0]  out_byte_next;

    logic [POS_W-1:0]   pos_addr;
    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_rdata;
    row_t               rd_row;
    row_t               reset_row;
    row_t               upd_row;
    slot_t              rd_slot;

    assign pos_addr = POS_W'(32'(row_idx_reg) * 32'(GRID_WIDTH) + 32'(col_reg));
    assign rd_row   = row_t'(ram_rdata);
    assign rd_slot  = rd_row[sel_reg[IDX_W-1:0]];

    always_comb
    begin
        for (int k = 0; k < TOP; k++)
        begin
            reset_row[k].dval  = FAR_DISTANCE;
            reset_row[k].label = '0;
            reset_row[k].obyte = '0;
        end
        upd_row = slots_reg;
        upd_row[worst_idx_reg].dval  = dist_reg;
        upd_row[worst_idx_reg].label = label_reg;
        upd_row[worst_idx_reg].obyte = obyte_reg;
    end

    assign ram_we    = cmd.init_wr | cmd.clear_wr | cmd.update_wr;
    assign ram_waddr = cmd.init_wr ? init_cnt_reg : pos_addr;
    assign ram_wdata = cmd.update_wr ? ROW_BITS'(upd_row) : ROW_BITS'(reset_row);

    tknst_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (POSITIONS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (pos_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.init_last = (init_cnt_reg == POS_W'(POSITIONS - 1));
        sts.skip      = (32'(row_idx_reg) >= 32'(GRID_HEIGHT))
                      || (32'(col_reg) >= 32'(GRID_WIDTH))
                      || ((op_reg != OP_CLEAR) && (op_reg != OP_OFFER) && (op_reg != OP_READ))
                      || ((op_reg == OP_OFFER) && (32'(label_reg) >= MAX_SAMPLES))
                      || ((op_reg == OP_READ) && (32'(sel_reg) >= 32'(TOP)));
        sts.op_clear  = (op_reg == OP_CLEAR);
        sts.op_read   = (op_reg == OP_READ);
        sts.scan_last = (idx_reg == IDX_W'(TOP - 1));
        sts.better    = (dist_reg < worst_dist_reg);
    end

    // clearing pass counter
    assign init_cnt_next = cmd.init_wr ? init_cnt_reg + POS_W'(1) : init_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
        end
        else
        begin
            init_cnt_reg <= init_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            row_idx_reg <= row;
            col_reg     <= col;
            sel_reg     <= slot_sel;
            dist_reg    <= distance;
            label_reg   <= sample_index;
            obyte_reg   <= sample_output;
        end
        if (cmd.load)
        begin
            slots_reg      <= rd_row;
            worst_dist_reg <= rd_row[0].dval;
            worst_idx_reg  <= '0;
            idx_reg        <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (slots_reg[idx_reg].dval > worst_dist_reg)
            begin
                worst_dist_reg <= slots_reg[idx_reg].dval;
                worst_idx_reg  <= idx_reg;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // result word, zero outside the strobe cycle
    always_comb
    begin
        done_next         = cmd.emit_zero | cmd.emit_read | cmd.emit_update;
        accepted_next     = cmd.emit_update;
        slot_next         = '0;
        out_distance_next = '0;
        out_label_next    = '0;
        out_byte_next     = '0;
        if (cmd.emit_update)
        begin
            slot_next         = SEL_W'(worst_idx_reg);
            out_distance_next = dist_reg;
            out_label_next    = label_reg;
            out_byte_next     = obyte_reg;
        end
        else if (cmd.emit_read)
        begin
            slot_next         = sel_reg;
            out_distance_next = rd_slot.dval;
            out_label_next    = rd_slot.label;
            out_byte_next     = rd_slot.obyte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done         <= 1'b0;
            accepted     <= 1'b0;
            slot         <= '0;
            out_distance <= '0;
            out_label    <= '0;
            out_byte     <= '0;
        end
        else
        begin
            done         <= done_next;
            accepted     <= accepted_next;
            slot         <= slot_next;
            out_distance <= out_distance_next;
            out_label    <= out_label_next;
            out_byte     <= out_byte_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tknst_checker.sv =====
// port-level checks of the top-k slot tracker and their bind
`default_nettype none

`include "top_k_nearest_slot_tracker_macros.svh"

module tknst_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic                          accepted,
    input wire logic [tknst_pkg::SEL_W-1:0]   slot,
    input wire logic [tknst_pkg::DIST_W-1:0]  out_distance
);

    import tknst_pkg::*;

    // a taken word keeps the block busy until its result
    `TKNST_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
    // the result cycle is also the cycle the block frees up
    `TKNST_ASSERT_SAME(a_done_free, clk, rst_n, done, !busy)
    `TKNST_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // stored distances never rise above the reset distance
    `TKNST_ASSERT_SAME(a_dist_bound, clk, rst_n, done, out_distance <= FAR_DISTANCE)
    `TKNST_ASSERT_SAME(a_quiet_word, clk, rst_n, !done, !accepted && (slot == '0))

endmodule

bind top_k_nearest_slot_tracker tknst_checker u_tknst_checker (.*);

`default_nettype wire
